/* rtl/iss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// Shared command and status types for the integer set sorter.
// ----------------------------------------------------------------------------
package iss_pkg;

    localparam int unsigned DATA_W = 32;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture incoming element, pos from count
        logic rd_prev;     // read entry pos-1
        logic shift;       // move read word up to pos, step pos down, read pos-2
        logic place;       // write element at pos, bump count
        logic set_ovf;     // element dropped
        logic emit_first;  // read entry 0 for output
        logic out_load;    // move read word into output register
        logic advance;     // next output index, read it
        logic done_set;    // clear count and overflow
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic pos_one;
        logic greater;
        logic last;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/iss_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_ctrl
// Sequencer for insertion into the store and ordered readout.
// ----------------------------------------------------------------------------
module iss_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  iss_pkg::sts_t sts,
    output iss_pkg::cmd_t cmd,
    output logic          in_stall
);
    import iss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_CMP,
        ST_PLACE,
        ST_ERD,
        ST_ELD
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                if (sts.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = sts.last ? ST_ERD : ST_IDLE;
                end
                else if (sts.pos_zero)
                begin
                    cmd.place  = 1'b1;
                    state_next = sts.last ? ST_ERD : ST_IDLE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = sts.last ? ST_ERD : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = sts.last ? ST_ERD : ST_IDLE;
            end
            ST_ERD:
            begin
                cmd.emit_first = 1'b1;
                state_next     = ST_ELD;
            end
            ST_ELD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.emit_last)
                    begin
                        cmd.done_set = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = stall_reg;

endmodule

/* rtl/iss_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_dp
// Element store, insertion pointer, counters and output register.
// ----------------------------------------------------------------------------
module iss_dp
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  iss_pkg::cmd_t                cmd,
    output iss_pkg::sts_t                sts,
    input  logic signed [iss_pkg::DATA_W-1:0] value,
    input  logic                         last,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic signed [iss_pkg::DATA_W-1:0] sorted_value,
    output logic                         final_res,
    output logic                         truncated
);
    import iss_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [DATA_W-1:0] mem [MAX_ITEMS];
    logic [DATA_W-1:0] rd_q;
    logic              rd_en;
    logic [AW-1:0]     raddr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;

    logic [DATA_W-1:0] v_reg;
    logic              last_reg;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     k_reg;
    logic [CW-1:0]     count_reg;
    logic              ovf_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_final_reg;
    logic              out_trunc_reg;

    // one write and one read port
    always_comb
    begin
        rd_en = cmd.rd_prev | cmd.shift | cmd.emit_first | cmd.advance;
        raddr = '0;
        if (cmd.rd_prev)
        begin
            raddr = pos_reg - AW'(1);
        end
        else if (cmd.shift)
        begin
            raddr = pos_reg - AW'(2);
        end
        else if (cmd.advance)
        begin
            raddr = k_reg + AW'(1);
        end
        we    = cmd.shift | cmd.place;
        waddr = pos_reg;
        wdata = cmd.shift ? rd_q : v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_q <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= value;
            last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            k_reg     <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= count_reg[AW-1:0];
            end
            else if (cmd.shift)
            begin
                pos_reg <= pos_reg - AW'(1);
            end
            if (cmd.emit_first)
            begin
                k_reg <= '0;
            end
            else if (cmd.advance)
            begin
                k_reg <= k_reg + AW'(1);
            end
            if (cmd.done_set)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.place)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg  <= rd_q;
            out_final_reg <= sts.emit_last;
            out_trunc_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        sts.full      = (count_reg == CW'(MAX_ITEMS));
        sts.pos_zero  = (pos_reg == '0);
        sts.pos_one   = (pos_reg == AW'(1));
        sts.greater   = ($signed(rd_q) > $signed(v_reg));
        sts.last      = last_reg;
        sts.emit_last = ((CW'(k_reg) + CW'(1)) == count_reg);
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_data_reg;
    assign final_res    = out_final_reg;
    assign truncated    = out_trunc_reg;

endmodule

/* rtl/integer_set_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_sorter
// Collects a set of signed words and returns it in ascending order.
// ----------------------------------------------------------------------------
// insertion: elements are taken only while the sequencer is idle; in_stall then
//   stays high while the walk shifts each larger stored element up one entry
// readout: after the last element is placed, entry 0 is read and loaded into
//   the output register; results follow one per cycle unless out_stall is high
// input stays stalled until the whole set has been read out: a new set is taken
//   only after the last result of the previous set is loaded for output
// reset: asynchronous, active low; clears count, overflow flag, pointers, fsm
//   and output valid; store contents are left as is
// ----------------------------------------------------------------------------
module integer_set_sorter
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [iss_pkg::DATA_W-1:0] value,
    input  logic                              last,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [iss_pkg::DATA_W-1:0] sorted_value,
    output logic                              final_res,
    output logic                              truncated
);
    import iss_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: insertion walk and readout
    iss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // store kept sorted as elements arrive; readout walks it from entry 0
    iss_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .last         (last),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .truncated    (truncated)
    );

endmodule

/* rtl/iss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks for the integer set sorter.
// ----------------------------------------------------------------------------
module iss_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [iss_pkg::DATA_W-1:0] sorted_value,
    input logic                              final_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value))
        else $error("result dropped or changed under stall");

    // block goes busy after each input transaction
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("no busy cycle after input transaction");

    // readout streams without gaps until the final result
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !final_res |=> out_valid)
        else $error("gap inside readout");

    // while taking input, only a final result may still wait
    a_idle_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_stall |-> final_res)
        else $error("input taken during readout");

endmodule

bind integer_set_sorter iss_checker u_iss_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_res    (final_res)
);

/* dv/iss_sort_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_sort_check_pkg
// Sorted-set prediction and result checking for the integer set sorter.
// ----------------------------------------------------------------------------
package iss_sort_check_pkg;

    import iss_pkg::DATA_W;

    typedef struct {
        logic signed [DATA_W-1:0] word;
        logic                     final_flag;
        logic                     trunc_flag;
    } sorted_entry_t;

    class sort_scoreboard;

        int                       capacity;
        logic signed [DATA_W-1:0] held_elements[$];
        bit                       held_dropped;
        sorted_entry_t            pending_sorted[$];
        int                       mismatches;

        function new(int cap);
            capacity     = cap;
            held_dropped = 1'b0;
            mismatches   = 0;
        endfunction

        // one accepted input transaction
        function void note_element(logic signed [DATA_W-1:0] v, logic is_last);
            int            pos;
            sorted_entry_t entry;
            if (held_elements.size() < capacity)
            begin
                // keep equal words in arrival order, after the ones already held
                pos = held_elements.size();
                while (pos > 0 && held_elements[pos-1] > v)
                    pos--;
                held_elements.insert(pos, v);
            end
            else
                held_dropped = 1'b1;
            if (is_last)
            begin
                foreach (held_elements[k])
                begin
                    entry.word       = held_elements[k];
                    entry.final_flag = (k == held_elements.size() - 1);
                    entry.trunc_flag = held_dropped;
                    pending_sorted.push_back(entry);
                end
                held_elements.delete();
                held_dropped = 1'b0;
            end
        endfunction

        // one accepted result transaction
        function void check_sorted(logic signed [DATA_W-1:0] v, logic fin, logic trn);
            sorted_entry_t exp_entry;
            if (pending_sorted.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d final %0b truncated %0b",
                             v, fin, trn);
                return;
            end
            exp_entry = pending_sorted.pop_front();
            if (v !== exp_entry.word || fin !== exp_entry.final_flag ||
                trn !== exp_entry.trunc_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                             exp_entry.word, exp_entry.final_flag, exp_entry.trunc_flag,
                             v, fin, trn);
            end
        endfunction

        function int pending();
            return pending_sorted.size();
        endfunction

    endclass

endpackage

/* dv/integer_set_sorter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_sorter_test
// Feeds sets of signed words with random gaps and output stalls, predicts the
// ascending readout with its final and truncation marks, and checks every
// result transaction in order.
// ----------------------------------------------------------------------------
module integer_set_sorter_test;

    import iss_pkg::DATA_W;
    import iss_sort_check_pkg::*;

    localparam int SET_CAPACITY = 64;
    localparam int RANDOM_ITEMS = 260;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    // every block input known from time zero
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     last      = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     truncated;

    sort_scoreboard           board;
    logic signed [DATA_W-1:0] set_words[$];
    int                       items_sent = 0;
    int                       send_gap_pct = 21;
    int                       recv_stall_pct = 54;

    integer_set_sorter #(
        .MAX_ITEMS(SET_CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .last(last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .final_res(final_res),
        .truncated(truncated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: check on every accepted result, then roll the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_sorted(sorted_value, final_res, truncated);
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // one input transaction; values read right after the edge are pre-edge values
    task send_element(input logic signed [DATA_W-1:0] v, input logic is_last);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_element(v, is_last);
        items_sent++;
    endtask

    // sends the words of set_words as one set, the final one marked
    task push_set();
        // idling pattern moves on only between sets
        if (items_sent < 100)
        begin
            send_gap_pct   = 21;
            recv_stall_pct = 54;
        end
        else if (items_sent < 190)
        begin
            send_gap_pct   = 54;
            recv_stall_pct = 21;
        end
        else
        begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        foreach (set_words[k])
            send_element(set_words[k], k == set_words.size() - 1);
        set_words.delete();
    endtask

    task push_random_set(input int set_size);
        int                       bias;
        int                       roll;
        logic signed [DATA_W-1:0] w;
        // some sets lean on a narrow range so duplicates are common
        bias = $urandom_range(0, 2);
        repeat (set_size)
        begin
            roll = $urandom_range(0, 9);
            if (roll == 0)
                w = WORD_MIN;
            else if (roll == 1)
                w = WORD_MAX;
            else if (bias == 0 && roll < 8)
                w = $signed($urandom_range(0, 8)) - 4;
            else
                w = $urandom;
            set_words.push_back(w);
        end
        push_set();
    endtask

    initial
    begin
        int set_size;
        board = new(SET_CAPACITY);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element sets at both extremes
        set_words = '{WORD_MIN};
        push_set();
        set_words = '{WORD_MAX};
        push_set();
        // extremes, zero and duplicates mixed
        set_words = '{0, -1, 1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 0};
        push_set();
        // already ascending: no element has to move
        set_words = '{-3, -2, -1, 0, 1, 2};
        push_set();
        // descending: every element moves past all stored ones
        set_words = '{5, 4, 3, 2, 1, 0, -1};
        push_set();

        // one over capacity drops the marked element itself, then exactly full
        push_random_set(SET_CAPACITY + 1);
        push_random_set(SET_CAPACITY);
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
                set_size = $urandom_range(SET_CAPACITY - 2, SET_CAPACITY + 4);
            else
                set_size = $urandom_range(1, 8);
            // keep the total close to the item budget
            if (set_size > RANDOM_ITEMS - items_sent)
                set_size = RANDOM_ITEMS - items_sent;
            push_random_set(set_size);
        end
        in_valid <= 1'b0;

        // drain, then keep waiting on the readout for stray results
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/iss_pkg.sv
rtl/iss_ctrl.sv
rtl/iss_dp.sv
rtl/integer_set_sorter.sv
rtl/iss_checker.sv
dv/iss_sort_check_pkg.sv
dv/integer_set_sorter_test.sv
